// File: rtl/ethp_pkg.sv
`timescale 1ns / 1ps

package ethp_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 17;

    // result kinds
    localparam logic [1:0] KIND_IGNORED   = 2'd0;
    localparam logic [1:0] KIND_MALFORMED = 2'd1;
    localparam logic [1:0] KIND_ARP_REPLY = 2'd2;
    localparam logic [1:0] KIND_TCP       = 2'd3;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;

    localparam logic [15:0] ARP_REPLY_OPCODE = 16'd2;
    localparam logic [3:0]  IPV4_VERSION     = 4'd4;
    localparam logic [7:0]  IP_PROTO_TCP     = 8'd6;
    localparam logic [4:0]  FRAG_HI_MASK     = 5'h1F;

    localparam int ETH_HDR_BYTES     = 14;
    localparam int ARP_BODY_BYTES    = 28;
    localparam int IP_MIN_HDR_BYTES  = 20;
    localparam int TCP_MIN_HDR_BYTES = 20;

    // fixed capture offsets from frame start
    localparam int OFS_ETYPE_HI  = 12;
    localparam int OFS_ETYPE_LO  = 13;
    localparam int OFS_VER_IHL   = 14;
    localparam int OFS_TLEN_HI   = 16;
    localparam int OFS_TLEN_LO   = 17;
    localparam int OFS_FRAG_HI   = 20;
    localparam int OFS_FRAG_LO   = 21;
    localparam int OFS_PROTO     = 23;
    localparam int OFS_SRC_FIRST = 26;
    localparam int OFS_SRC_LAST  = 29;
    localparam int OFS_DST_FIRST = 30;
    localparam int OFS_DST_LAST  = 33;

    // TCP offsets relative to the start of the TCP header
    localparam int TCP_OFS_PORT_HI = 2;
    localparam int TCP_OFS_PORT_LO = 3;
    localparam int TCP_OFS_HLEN    = 12;
    localparam int TCP_OFS_FLAGS   = 13;

    typedef struct packed {
        logic [15:0] ether_type;
        logic [15:0] arp_opcode;
        logic [3:0]  ip_version;
        logic [3:0]  ip_header_words;
        logic [15:0] ip_total_length;
        logic [7:0]  ip_protocol;
        logic        fragment_nonzero;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] dest_port;
        logic [3:0]  tcp_header_words;
        logic [7:0]  seg_flags;
    } t_hdr;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
        logic [7:0]  flag_bits;
        logic [7:0]  payload_start;
        logic [15:0] payload_length;
    } t_result;

endpackage

// File: rtl/ethp_capture.sv
`timescale 1ns / 1ps

module ethp_capture #(
    parameter int COUNT_WIDTH = ethp_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  logic                   i_last,
    input  logic [7:0]             i_data,
    output logic [COUNT_WIDTH-1:0] o_idx,
    output ethp_pkg::t_hdr         o_hdr
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] r_count;
    ethp_pkg::t_hdr         r_hdr;
    ethp_pkg::t_hdr         n_hdr;
    logic [6:0]             w_base;
    logic [COUNT_WIDTH-1:0] w_tcp0;

    assign w_base = 7'(ethp_pkg::ETH_HDR_BYTES) + {1'b0, r_hdr.ip_header_words, 2'b00};
    assign w_tcp0 = COUNT_WIDTH'(w_base);

    // header fields with the current byte folded in
    always_comb begin
        n_hdr = r_hdr;
        if (r_count == COUNT_WIDTH'(ethp_pkg::OFS_ETYPE_HI)) n_hdr.ether_type[15:8] = i_data;
        if (r_count == COUNT_WIDTH'(ethp_pkg::OFS_ETYPE_LO)) n_hdr.ether_type[7:0] = i_data;
        if (r_count == COUNT_WIDTH'(ethp_pkg::OFS_VER_IHL)) begin
            n_hdr.ip_version      = i_data[7:4];
            n_hdr.ip_header_words = i_data[3:0];
        end
        if (r_count == COUNT_WIDTH'(ethp_pkg::OFS_TLEN_HI)) n_hdr.ip_total_length[15:8] = i_data;
        if (r_count == COUNT_WIDTH'(ethp_pkg::OFS_TLEN_LO)) n_hdr.ip_total_length[7:0] = i_data;
        if (r_count == COUNT_WIDTH'(ethp_pkg::OFS_FRAG_HI)) begin
            n_hdr.arp_opcode[15:8] = i_data;
            if ((i_data[4:0] & ethp_pkg::FRAG_HI_MASK) != 5'd0) n_hdr.fragment_nonzero = 1'b1;
        end
        if (r_count == COUNT_WIDTH'(ethp_pkg::OFS_FRAG_LO)) begin
            n_hdr.arp_opcode[7:0] = i_data;
            if (i_data != 8'd0) n_hdr.fragment_nonzero = 1'b1;
        end
        if (r_count == COUNT_WIDTH'(ethp_pkg::OFS_PROTO)) n_hdr.ip_protocol = i_data;
        if (r_count >= COUNT_WIDTH'(ethp_pkg::OFS_SRC_FIRST)
                && r_count <= COUNT_WIDTH'(ethp_pkg::OFS_SRC_LAST)) begin
            n_hdr.src_addr = {r_hdr.src_addr[23:0], i_data};
        end
        if (r_count >= COUNT_WIDTH'(ethp_pkg::OFS_DST_FIRST)
                && r_count <= COUNT_WIDTH'(ethp_pkg::OFS_DST_LAST)) begin
            n_hdr.dst_addr = {r_hdr.dst_addr[23:0], i_data};
        end
        if (r_count == w_tcp0 + COUNT_WIDTH'(ethp_pkg::TCP_OFS_PORT_HI)) begin
            n_hdr.dest_port[15:8] = i_data;
        end
        if (r_count == w_tcp0 + COUNT_WIDTH'(ethp_pkg::TCP_OFS_PORT_LO)) begin
            n_hdr.dest_port[7:0] = i_data;
        end
        if (r_count == w_tcp0 + COUNT_WIDTH'(ethp_pkg::TCP_OFS_HLEN)) begin
            n_hdr.tcp_header_words = i_data[7:4];
        end
        if (r_count == w_tcp0 + COUNT_WIDTH'(ethp_pkg::TCP_OFS_FLAGS)) begin
            n_hdr.seg_flags = i_data;
        end
    end

    // clear everything after the final byte of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hdr   <= '0;
        end else if (i_advance) begin
            if (i_last) begin
                r_count <= '0;
                r_hdr   <= '0;
            end else begin
                r_hdr <= n_hdr;
                if (r_count != CNT_MAX) r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_idx = r_count;
    assign o_hdr = n_hdr;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_last |=> r_count == '0 && r_hdr == '0)
        else $error("capture state not cleared after final byte");

endmodule

// File: rtl/ethp_classify.sv
`timescale 1ns / 1ps

module ethp_classify #(
    parameter int COUNT_WIDTH = ethp_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic [COUNT_WIDTH-1:0] i_idx,
    input  ethp_pkg::t_hdr         i_hdr,
    output ethp_pkg::t_result      o_res
);

    // idx is the offset of the final byte, so captured length is idx + 1
    logic [COUNT_WIDTH-1:0] w_avail;
    logic [5:0]             w_ihl;
    logic [5:0]             w_thl;
    logic [15:0]            w_total;
    logic [15:0]            w_tavail;

    assign w_avail  = i_idx - COUNT_WIDTH'(ethp_pkg::ETH_HDR_BYTES - 1);
    assign w_ihl    = {i_hdr.ip_header_words, 2'b00};
    assign w_thl    = {i_hdr.tcp_header_words, 2'b00};
    assign w_total  = (w_avail < COUNT_WIDTH'(i_hdr.ip_total_length)) ? w_avail[15:0]
                                                                       : i_hdr.ip_total_length;
    assign w_tavail = w_total - 16'(w_ihl);

    always_comb begin
        o_res = '0;
        priority if (i_idx < COUNT_WIDTH'(ethp_pkg::ETH_HDR_BYTES - 1)) begin
            o_res.kind = ethp_pkg::KIND_MALFORMED;
        end else if (i_hdr.ether_type == ethp_pkg::ETYPE_ARP) begin
            if (i_idx < COUNT_WIDTH'(ethp_pkg::ETH_HDR_BYTES + ethp_pkg::ARP_BODY_BYTES - 1)) begin
                o_res.kind = ethp_pkg::KIND_MALFORMED;
            end else if (i_hdr.arp_opcode == ethp_pkg::ARP_REPLY_OPCODE) begin
                o_res.kind = ethp_pkg::KIND_ARP_REPLY;
            end
        end else if (i_hdr.ether_type != ethp_pkg::ETYPE_IPV4) begin
            o_res.kind = ethp_pkg::KIND_IGNORED;
        end else if (i_idx < COUNT_WIDTH'(ethp_pkg::ETH_HDR_BYTES
                                          + ethp_pkg::IP_MIN_HDR_BYTES - 1)) begin
            o_res.kind = ethp_pkg::KIND_MALFORMED;
        end else if (i_hdr.ip_version != ethp_pkg::IPV4_VERSION) begin
            o_res.kind = ethp_pkg::KIND_MALFORMED;
        end else if (w_ihl < 6'(ethp_pkg::IP_MIN_HDR_BYTES)
                     || COUNT_WIDTH'(w_ihl) > w_avail) begin
            o_res.kind = ethp_pkg::KIND_MALFORMED;
        end else if (i_hdr.ip_total_length < 16'(w_ihl)) begin
            o_res.kind = ethp_pkg::KIND_MALFORMED;
        end else if (i_hdr.ip_protocol != ethp_pkg::IP_PROTO_TCP || i_hdr.fragment_nonzero) begin
            o_res.kind = ethp_pkg::KIND_IGNORED;
        end else if (w_tavail < 16'(ethp_pkg::TCP_MIN_HDR_BYTES)) begin
            o_res.kind = ethp_pkg::KIND_MALFORMED;
        end else if (w_thl < 6'(ethp_pkg::TCP_MIN_HDR_BYTES) || 16'(w_thl) > w_tavail) begin
            o_res.kind = ethp_pkg::KIND_MALFORMED;
        end else begin
            o_res.kind           = ethp_pkg::KIND_TCP;
            o_res.source_address = i_hdr.src_addr;
            o_res.dest_address   = i_hdr.dst_addr;
            o_res.dest_port      = i_hdr.dest_port;
            o_res.flag_bits      = i_hdr.seg_flags;
            o_res.payload_start  = 8'(ethp_pkg::ETH_HDR_BYTES) + 8'(w_ihl) + 8'(w_thl);
            o_res.payload_length = w_tavail - 16'(w_thl);
        end
    end

endmodule

// File: rtl/eth_arp_ipv4_tcp_header_parser.sv
`timescale 1ns / 1ps

// Ethernet frame classifier: ARP reply detection and IPv4/TCP header extraction.
//
// Input channel (i_valid / o_ready): one frame byte per item, in wire order,
// with i_last_byte set on the final captured byte. Output channel
// (o_valid / i_ready): one result item per frame, issued for its final byte:
// kind (ignored, malformed, ARP reply, TCP) plus TCP addresses, destination
// port, flags, payload start and payload length, all zero unless TCP.
//
// Throughput: one byte per cycle, including across frame borders, while no
// final byte waits. The final byte passes through the input register and
// then the result register, which drives o_valid.
// Every byte passes through the input register and the capture/classify
// logic; only a final byte waits when the result register is still full
// and i_ready is low, and it then stalls o_ready.
//
// Reset (synchronous, active low) clears the byte counter, all captured
// header fields and both valid flags; each final byte clears the counter
// and fields too, so the next item starts a new frame. The byte counter
// saturates; bytes beyond its range are seen at its last offset.
module eth_arp_ipv4_tcp_header_parser #(
    parameter int COUNT_WIDTH = ethp_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_source_address,
    output logic [31:0] o_dest_address,
    output logic [15:0] o_dest_port,
    output logic [7:0]  o_flag_bits,
    output logic [7:0]  o_payload_start,
    output logic [15:0] o_payload_length
);

    logic                   r_in_valid;
    logic [7:0]             r_in_data;
    logic                   r_in_last;
    logic                   r_out_valid;
    ethp_pkg::t_result      r_res;
    logic                   w_advance;
    logic [COUNT_WIDTH-1:0] w_idx;
    ethp_pkg::t_hdr         w_hdr;
    ethp_pkg::t_result      w_res;

    // a non-final byte never needs the output; a final one needs room there
    assign w_advance = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    // input register: hold the byte until it is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    ethp_capture #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(w_advance),
        .i_last   (r_in_last),
        .i_data   (r_in_data),
        .o_idx    (w_idx),
        .o_hdr    (w_hdr)
    );

    ethp_classify #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_classify (
        .i_idx(w_idx),
        .i_hdr(w_hdr),
        .o_res(w_res)
    );

    // result register: load on a final byte, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_res <= w_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_res.kind;
    assign o_source_address = r_res.source_address;
    assign o_dest_address   = r_res.dest_address;
    assign o_dest_port      = r_res.dest_port;
    assign o_flag_bits      = r_res.flag_bits;
    assign o_payload_start  = r_res.payload_start;
    assign o_payload_length = r_res.payload_length;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_data) && $stable(r_in_last))
        else $error("input register lost a waiting byte");

    a_non_tcp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.kind != ethp_pkg::KIND_TCP |->
            r_res.source_address == 32'd0 && r_res.dest_address == 32'd0
            && r_res.dest_port == 16'd0 && r_res.flag_bits == 8'd0
            && r_res.payload_start == 8'd0 && r_res.payload_length == 16'd0)
        else $error("non-TCP result carries nonzero fields");

    a_tcp_start_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.kind == ethp_pkg::KIND_TCP |->
            r_res.payload_start >= 8'(ethp_pkg::ETH_HDR_BYTES + ethp_pkg::IP_MIN_HDR_BYTES
                                      + ethp_pkg::TCP_MIN_HDR_BYTES)
            && r_res.payload_start <= 8'd134)
        else $error("TCP payload start out of range");

endmodule
